// File: rtl/range_value_set_table_core_assert.svh
// Assertion macros for the range/value set table core.
`ifndef RANGE_VALUE_SET_TABLE_CORE_ASSERT_SVH
`define RANGE_VALUE_SET_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define RVST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rvst assertion failed");
// Next-cycle implication, disabled during reset.
`define RVST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rvst assertion failed");
`else
`define RVST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RVST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/rvst_pkg.sv
// Shared command codes and cell flag types for the range/value set table.
package rvst_pkg;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_ADD_RANGE = 3'd1;
    localparam logic [2:0] CMD_ADD_VALUE = 3'd2;
    localparam logic [2:0] CMD_LOOKUP    = 3'd3;
    localparam logic [2:0] CMD_SUBSET    = 3'd4;

    typedef struct packed {
        logic hit;
        logic contains;
        logic nested;
        logic partial;
        logic malformed;
    } t_range_flags;

    typedef struct packed {
        logic hit;
        logic covered;
    } t_value_flags;

endpackage

// File: rtl/rvst_in_if.sv
// Request channel: command and operands, valid/ready handshake.
interface rvst_in_if #(
    parameter int CODE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           command;
    logic [CODE_BITS-1:0] first_value;
    logic [CODE_BITS-1:0] last_value;
    logic [CODE_BITS-1:0] probe_code;
    logic                 subset_end;

    modport source (
        output valid, command, first_value, last_value, probe_code, subset_end,
        input  ready
    );
    modport sink (
        input  valid, command, first_value, last_value, probe_code, subset_end,
        output ready
    );
endinterface

// File: rtl/rvst_out_if.sv
// Result channel: membership and conflict flags plus largest code.
interface rvst_out_if #(
    parameter int CODE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 member_hit;
    logic                 subset_all_present;
    logic                 value_made_redundant;
    logic                 contains_earlier;
    logic                 inside_earlier;
    logic                 partial_overlap;
    logic                 malformed_range;
    logic                 duplicate_value;
    logic                 table_full;
    logic [CODE_BITS-1:0] largest_code;

    modport source (
        output valid, member_hit, subset_all_present, value_made_redundant,
               contains_earlier, inside_earlier, partial_overlap, malformed_range,
               duplicate_value, table_full, largest_code,
        input  ready
    );
    modport sink (
        input  valid, member_hit, subset_all_present, value_made_redundant,
               contains_earlier, inside_earlier, partial_overlap, malformed_range,
               duplicate_value, table_full, largest_code,
        output ready
    );
endinterface

// File: rtl/rvst_range_cell.sv
// One range slot: holds a start/end pair, shifts it on, classifies the request.
module rvst_range_cell #(
    parameter int CODE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic                  i_active,
    input  logic [CODE_BITS-1:0]  i_prev_start,
    input  logic [CODE_BITS-1:0]  i_prev_end,
    input  logic [CODE_BITS-1:0]  i_lo,
    input  logic [CODE_BITS-1:0]  i_hi,
    input  logic [CODE_BITS-1:0]  i_key,
    output logic [CODE_BITS-1:0]  o_start,
    output logic [CODE_BITS-1:0]  o_end,
    output rvst_pkg::t_range_flags o_flags
);
    import rvst_pkg::*;

    logic [CODE_BITS-1:0] r_start;
    logic [CODE_BITS-1:0] r_end;
    logic                 w_contains;
    logic                 w_inside;
    logic                 w_part_lo;
    logic                 w_part_hi;
    logic                 w_disjoint;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_start <= i_prev_start;
            r_end   <= i_prev_end;
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;

    assign w_contains = (i_lo <= r_start) && (i_hi >= r_end);
    assign w_inside   = (i_lo >= r_start) && (i_hi <= r_end);
    assign w_part_lo  = (i_lo <= r_start) && (i_hi >= r_start) && (i_hi <= r_end);
    assign w_part_hi  = (i_hi > r_end) && (i_lo >= r_start) && (i_lo <= r_end);
    assign w_disjoint = ((i_lo < r_start) && (i_hi < r_start)) ||
                        ((i_lo > r_end) && (i_hi > r_end));

    // First matching test wins; no match at all means inverted bounds.
    always_comb begin
        o_flags = '0;
        if (i_active) begin
            o_flags.hit = (i_key >= r_start) && (i_key <= r_end);
            priority if (w_contains) begin
                o_flags.contains = 1'b1;
            end else if (w_inside) begin
                o_flags.nested = 1'b1;
            end else if (w_part_lo || w_part_hi) begin
                o_flags.partial = 1'b1;
            end else if (!w_disjoint) begin
                o_flags.malformed = 1'b1;
            end else begin
                // disjoint: no flag
            end
        end
    end
endmodule

// File: rtl/rvst_value_cell.sv
// One single-value slot: holds a code, shifts it on, tests the request.
module rvst_value_cell #(
    parameter int CODE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic                  i_active,
    input  logic [CODE_BITS-1:0]  i_prev_value,
    input  logic [CODE_BITS-1:0]  i_lo,
    input  logic [CODE_BITS-1:0]  i_hi,
    input  logic [CODE_BITS-1:0]  i_key,
    output logic [CODE_BITS-1:0]  o_value,
    output rvst_pkg::t_value_flags o_flags
);
    import rvst_pkg::*;

    logic [CODE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_prev_value;
        end
    end

    assign o_value         = r_value;
    assign o_flags.hit     = i_active && (r_value == i_key);
    assign o_flags.covered = i_active && (r_value >= i_lo) && (r_value <= i_hi);
endmodule

// File: rtl/range_value_set_table_core.sv
// Top level of the range/value set table: cell rows, counters, result register.
//
// Usage
//   i_req carries one request per valid/ready handshake: command, first_value,
//   last_value, probe_code, subset_end. o_rsp returns exactly one result per
//   request, in order, with valid/ready.
//   Storage is two rows of cells, one for ranges and one for single codes. A
//   stored entry enters at cell 0 and every occupied cell passes its entry to
//   the next one; the fill counters say how many cells hold live entries.
//   Every live cell compares the request against its own entry in the same
//   cycle, and the flags are ORed across the row.
// Timing and throughput
//   The result of an accepted request is registered at the accepting edge and
//   shows on o_rsp right after it. One request per cycle: i_req.ready stays high
//   while the result register is empty or is being drained in the same cycle,
//   so the rate is set by the single result register and the receiver.
// Reset
//   i_rst_n (synchronous, active low) empties both tables, zeroes the
//   largest code, restarts any subset group and drops a pending result.
//   No clearing pass: cell contents are ignored above the fill counts.
// Stall
//   While o_rsp.ready is low with a result held, i_req.ready is low and the
//   result stays unchanged.
module range_value_set_table_core #(
    parameter int RANGE_SLOTS = 16,
    parameter int VALUE_SLOTS = 16,
    parameter int CODE_BITS   = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rvst_in_if.sink   i_req,
    rvst_out_if.source o_rsp
);
    import rvst_pkg::*;

`include "range_value_set_table_core_assert.svh"

    localparam int RCNT_W = $clog2(RANGE_SLOTS + 1);
    localparam int VCNT_W = $clog2(VALUE_SLOTS + 1);

    // control state
    logic [RCNT_W-1:0]    r_ranges_used, n_ranges_used;
    logic [VCNT_W-1:0]    r_values_used, n_values_used;
    logic [CODE_BITS-1:0] r_largest, n_largest;
    logic                 r_subset_run, n_subset_run;
    logic                 r_out_valid;

    // result register (payload, no reset)
    logic                 r_member, n_member;
    logic                 r_all, n_all;
    logic                 r_redund, n_redund;
    logic                 r_contains, n_contains;
    logic                 r_inside, n_inside;
    logic                 r_partial, n_partial;
    logic                 r_malformed, n_malformed;
    logic                 r_dup, n_dup;
    logic                 r_full, n_full;

    logic                 w_accept;
    logic                 w_rshift;
    logic                 w_vshift;
    logic                 w_rfull;
    logic                 w_vfull;
    logic [CODE_BITS-1:0] w_key;

    logic [CODE_BITS-1:0] w_rstart [RANGE_SLOTS];
    logic [CODE_BITS-1:0] w_rend   [RANGE_SLOTS];
    logic [CODE_BITS-1:0] w_vval   [VALUE_SLOTS];
    t_range_flags         w_rflags [RANGE_SLOTS];
    t_value_flags         w_vflags [VALUE_SLOTS];

    logic [RANGE_SLOTS-1:0] w_r_hit, w_r_cont, w_r_ins, w_r_part, w_r_mal;
    logic [VALUE_SLOTS-1:0] w_v_hit, w_v_cov;
    logic                   w_present;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_rfull = (r_ranges_used >= RCNT_W'(RANGE_SLOTS));
    assign w_vfull = (r_values_used >= VCNT_W'(VALUE_SLOTS));

    // add value tests first_value, lookups test probe_code
    assign w_key = (i_req.command == CMD_ADD_VALUE) ? i_req.first_value : i_req.probe_code;

    assign w_rshift = w_accept && (i_req.command == CMD_ADD_RANGE) && !w_rfull;
    assign w_vshift = w_accept && (i_req.command == CMD_ADD_VALUE) && !w_present && !w_vfull;

    // range row
    for (genvar g = 0; g < RANGE_SLOTS; g++) begin : g_range
        logic [CODE_BITS-1:0] w_prev_s;
        logic [CODE_BITS-1:0] w_prev_e;
        if (g == 0) begin : g_head
            assign w_prev_s = i_req.first_value;
            assign w_prev_e = i_req.last_value;
        end else begin : g_link
            assign w_prev_s = w_rstart[g-1];
            assign w_prev_e = w_rend[g-1];
        end
        rvst_range_cell #(.CODE_BITS(CODE_BITS)) u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_rshift),
            .i_active     (r_ranges_used > RCNT_W'(g)),
            .i_prev_start (w_prev_s),
            .i_prev_end   (w_prev_e),
            .i_lo         (i_req.first_value),
            .i_hi         (i_req.last_value),
            .i_key        (w_key),
            .o_start      (w_rstart[g]),
            .o_end        (w_rend[g]),
            .o_flags      (w_rflags[g])
        );
        assign w_r_hit[g]  = w_rflags[g].hit;
        assign w_r_cont[g] = w_rflags[g].contains;
        assign w_r_ins[g]  = w_rflags[g].nested;
        assign w_r_part[g] = w_rflags[g].partial;
        assign w_r_mal[g]  = w_rflags[g].malformed;
    end

    // single value row
    for (genvar g = 0; g < VALUE_SLOTS; g++) begin : g_value
        logic [CODE_BITS-1:0] w_prev_v;
        if (g == 0) begin : g_head
            assign w_prev_v = i_req.first_value;
        end else begin : g_link
            assign w_prev_v = w_vval[g-1];
        end
        rvst_value_cell #(.CODE_BITS(CODE_BITS)) u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_vshift),
            .i_active     (r_values_used > VCNT_W'(g)),
            .i_prev_value (w_prev_v),
            .i_lo         (i_req.first_value),
            .i_hi         (i_req.last_value),
            .i_key        (w_key),
            .o_value      (w_vval[g]),
            .o_flags      (w_vflags[g])
        );
        assign w_v_hit[g] = w_vflags[g].hit;
        assign w_v_cov[g] = w_vflags[g].covered;
    end

    assign w_present = (|w_r_hit) || (|w_v_hit);

    always_comb begin
        n_ranges_used = r_ranges_used;
        n_values_used = r_values_used;
        n_largest     = r_largest;
        n_subset_run  = r_subset_run;
        n_member      = 1'b0;
        n_all         = 1'b0;
        n_redund      = 1'b0;
        n_contains    = 1'b0;
        n_inside      = 1'b0;
        n_partial     = 1'b0;
        n_malformed   = 1'b0;
        n_dup         = 1'b0;
        n_full        = 1'b0;
        unique case (i_req.command)
            CMD_CLEAR: begin
                n_ranges_used = '0;
                n_values_used = '0;
                n_largest     = '0;
            end
            CMD_ADD_RANGE: begin
                n_redund    = |w_v_cov;
                n_contains  = |w_r_cont;
                n_inside    = |w_r_ins;
                n_partial   = |w_r_part;
                n_malformed = |w_r_mal;
                if (w_rfull) begin
                    n_full = 1'b1;
                end else begin
                    n_ranges_used = r_ranges_used + 1'b1;
                    // only the end counts, even for inverted bounds
                    if (i_req.last_value > r_largest) begin
                        n_largest = i_req.last_value;
                    end
                end
            end
            CMD_ADD_VALUE: begin
                priority if (w_present) begin
                    n_dup = 1'b1;
                end else if (w_vfull) begin
                    n_full = 1'b1;
                end else begin
                    n_values_used = r_values_used + 1'b1;
                    if (i_req.first_value > r_largest) begin
                        n_largest = i_req.first_value;
                    end
                end
            end
            CMD_LOOKUP: begin
                n_member = w_present;
            end
            CMD_SUBSET: begin
                n_member = w_present;
                if (i_req.subset_end) begin
                    n_all        = r_subset_run && w_present;
                    n_subset_run = 1'b1;
                end else begin
                    n_subset_run = r_subset_run && w_present;
                end
            end
            default: begin
                // unknown command: nothing changes, flags stay low
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranges_used <= '0;
            r_values_used <= '0;
            r_largest     <= '0;
            r_subset_run  <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ranges_used <= n_ranges_used;
                r_values_used <= n_values_used;
                r_largest     <= n_largest;
                r_subset_run  <= n_subset_run;
                r_out_valid   <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_member    <= n_member;
            r_all       <= n_all;
            r_redund    <= n_redund;
            r_contains  <= n_contains;
            r_inside    <= n_inside;
            r_partial   <= n_partial;
            r_malformed <= n_malformed;
            r_dup       <= n_dup;
            r_full      <= n_full;
        end
    end

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.member_hit           = r_member;
    assign o_rsp.subset_all_present   = r_all;
    assign o_rsp.value_made_redundant = r_redund;
    assign o_rsp.contains_earlier     = r_contains;
    assign o_rsp.inside_earlier       = r_inside;
    assign o_rsp.partial_overlap      = r_partial;
    assign o_rsp.malformed_range      = r_malformed;
    assign o_rsp.duplicate_value      = r_dup;
    assign o_rsp.table_full           = r_full;
    assign o_rsp.largest_code         = r_largest;

    // fill counts never run past the rows
    `RVST_ASSERT_SAME(a_counts_bounded, i_clk, i_rst_n, 1'b1,
        (r_ranges_used <= RCNT_W'(RANGE_SLOTS)) && (r_values_used <= VCNT_W'(VALUE_SLOTS)))
    // a stored range bumps the range count by exactly one
    `RVST_ASSERT_NEXT(a_range_store, i_clk, i_rst_n, w_rshift,
        r_ranges_used == $past(r_ranges_used) + 1'b1)
    // clear empties both rows and the largest code
    `RVST_ASSERT_NEXT(a_clear, i_clk, i_rst_n, w_accept && (i_req.command == CMD_CLEAR),
        (r_ranges_used == '0) && (r_values_used == '0) && (r_largest == '0))
    // a duplicate is never also reported as dropped for lack of room
    `RVST_ASSERT_SAME(a_dup_not_full, i_clk, i_rst_n, r_out_valid, !(r_dup && r_full))

endmodule
